// ===== rtl/kfe_pkg.sv =====
package kfe_pkg;

    localparam int MAX_FEATURES = 1024;
    localparam int CNT_W        = $clog2(MAX_FEATURES + 1);
    localparam int SUM_W        = 48;
    localparam int TAYLOR_TERMS = 20;
    localparam int DIV_STEPS    = 8;
    localparam int SDIV_STEPS   = 18;

    localparam logic [63:0] LN2_Q58  = 64'h02C5C85FDF473DE7;
    localparam logic [63:0] ONE_Q62  = 64'h4000000000000000;
    localparam logic [63:0] REM_BIAS = 64'd24 * LN2_Q58;
    localparam logic signed [5:0] N_START = -6'sd24;

    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_POLY    = 2'd1;
    localparam logic [1:0] MODE_GAUSS   = 2'd2;
    localparam logic [1:0] MODE_SIGMOID = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SCALE  = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;
    localparam logic [1:0] CFG_DEGREE = 2'd3;

    localparam logic [1:0]  RST_MODE   = MODE_GAUSS;
    localparam logic [23:0] RST_SCALE  = 24'd6554;
    localparam logic [23:0] RST_OFFSET = 24'd0;
    localparam logic [3:0]  RST_DEGREE = 4'd1;

    typedef struct packed {
        logic signed [15:0] x1_feature;
        logic signed [15:0] x2_feature;
        logic               last_feature;
    } t_kfe_in;

    typedef struct packed {
        logic signed [31:0] kernel_value;
        logic               saturated;
    } t_kfe_out;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCUM,
        DP_MULH,
        DP_MULL,
        DP_SUMT,
        DP_DISPATCH,
        DP_PMUL,
        DP_PCLAMP,
        DP_RED,
        DP_TINIT,
        DP_PP,
        DP_DLOAD,
        DP_DIV,
        DP_TACC,
        DP_GFIN,
        DP_SLOAD,
        DP_SDIV,
        DP_SFIN,
        DP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] pp_sel;
        logic [4:0] divisor;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic rem_ge;
    } t_dp_stat;

endpackage

// ===== rtl/kernel_function_evaluator_top.sv =====
// Kernel function evaluator for one pair of feature vectors.
// The input channel carries one matching Q4.12 feature pair per transaction,
// with a flag on the final pair. Each transaction that is not flagged last is
// accumulated, and the next one can be taken in the following cycle.
// The last transaction starts the evaluation. Polynomial mode multiplies and
// clamps once per degree. Gaussian and sigmoid modes run a range reduction and
// a 20-term series that uses one shared 32x32 partial-product multiplier and
// an 8-bit-per-cycle divider; sigmoid adds a final 18-bit divide.
// The result waits in an output register; transactions are still accepted while it
// waits, but a finished evaluation holds, with the input stalled, until the receiver
// takes the result.
// The configuration channel is always ready and writes one register per transaction.
// Reset clears the accumulator and loads the default registers (Gaussian mode).
module kernel_function_evaluator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kfe_pkg::t_kfe_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output kfe_pkg::t_kfe_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data
);
    import kfe_pkg::*;

    logic [1:0]  r_mode;
    logic [23:0] r_scale;
    logic [23:0] r_offset;
    logic [3:0]  r_degree;
    logic        r_out_valid;
    t_kfe_out    r_out;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    t_kfe_out    w_result;
    logic        w_out_load;
    logic        w_out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_scale  <= RST_SCALE;
            r_offset <= RST_OFFSET;
            r_degree <= RST_DEGREE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                CFG_DEGREE: r_degree <= i_cfg_data[3:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    kfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_feature),
        .i_mode     (r_mode),
        .i_degree   (r_degree),
        .i_stat     (w_stat),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    kfe_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_in_data),
        .i_mode   (r_mode),
        .i_scale  (r_scale),
        .i_offset (r_offset),
        .i_degree (r_degree),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("Pending result overwritten.");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.last_feature) |=> !o_in_ready)
        else $error("Input taken during evaluation.");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !o_in_ready)
        else $error("Result loaded while idle.");

endmodule

// ===== rtl/kfe_datapath.sv =====
module kfe_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kfe_pkg::t_dp_cmd i_cmd,
    input  kfe_pkg::t_kfe_in i_item,
    input  logic [1:0]       i_mode,
    input  logic [23:0]      i_scale,
    input  logic [23:0]      i_offset,
    input  logic [3:0]       i_degree,
    output kfe_pkg::t_dp_stat o_stat,
    output kfe_pkg::t_kfe_out o_result
);
    import kfe_pkg::*;

    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [43:0]      r_ph;
    logic signed [44:0]      r_pl;
    logic signed [47:0]      r_t;
    logic signed [31:0]      r_res;
    logic                    r_sat;
    logic signed [31:0]      r_tc;
    logic signed [63:0]      r_prod;
    logic [63:0]             r_rem;
    logic signed [5:0]       r_n;
    logic [63:0]             r_rq;
    logic [63:0]             r_term;
    logic [63:0]             r_esum;
    logic [127:0]            r_acc;
    logic [63:0]             r_dq;
    logic [4:0]              r_dr;
    logic                    r_neg;
    logic [57:0]             r_snum;
    logic [58:0]             r_sden;
    logic [17:0]             r_q;

    logic signed [16:0] w_df;
    logic signed [33:0] w_term_in;
    logic signed [48:0] w_acc;
    logic signed [SUM_W-1:0] w_acc_sat;
    logic signed [39:0] w_d;
    logic signed [63:0] w_st;
    logic signed [48:0] w_tcf;
    logic               w_tc_ovf;
    logic               w_tc_unf;
    logic signed [31:0] w_tcc;
    logic               w_d_ovf;
    logic               w_d_unf;
    logic signed [48:0] w_ga;
    logic               w_g_hi;
    logic               w_g_lo;
    logic [48:0]        w_smag;
    logic               w_s_big;
    logic [20:0]        w_a21;
    logic [63:0]        w_big;
    logic               w_early;
    logic signed [47:0] w_pv;
    logic [31:0]        w_pa;
    logic [31:0]        w_pb;
    logic [63:0]        w_pp;
    logic [127:0]       w_pps;
    logic [5:0]         w_rem6;
    logic [7:0]         w_qb;
    logic signed [7:0]  w_nx;
    logic signed [7:0]  w_gsh;
    logic [64:0]        w_gsum;
    logic [64:0]        w_gv;
    logic [5:0]         w_ssh;
    logic [40:0]        w_e40;
    logic [40:0]        w_nd;
    logic [41:0]        w_den;
    logic [58:0]        w_sub;

    assign w_df      = 17'(i_item.x1_feature) - 17'(i_item.x2_feature);
    assign w_term_in = (i_mode == MODE_GAUSS) ? 34'(w_df * w_df)
                                              : 34'(i_item.x1_feature * i_item.x2_feature);
    assign w_acc     = 49'(r_sum) + 49'(w_term_in);

    always_comb begin
        if (w_acc > 49'sd140737488355327) begin
            w_acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (w_acc < -49'sd140737488355328) begin
            w_acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            w_acc_sat = w_acc[SUM_W-1:0];
        end
    end

    assign w_d  = r_sum[47:8];
    assign w_st = {{r_ph[43]}, r_ph[42:0], 20'b0} + 64'(r_pl);

    assign w_tcf    = 49'(r_t) + 49'($signed(i_offset));
    assign w_tc_ovf = w_tcf > 49'sd2147483647;
    assign w_tc_unf = w_tcf < -49'sd2147483648;
    assign w_tcc    = w_tc_ovf ? 32'sh7FFFFFFF : (w_tc_unf ? 32'sh80000000 : w_tcf[31:0]);
    assign w_d_ovf  = w_d > 40'sd2147483647;
    assign w_d_unf  = w_d < -40'sd2147483648;

    assign w_ga    = -49'(r_t);
    assign w_g_hi  = w_ga > 49'sd720896;
    assign w_g_lo  = w_ga < -49'sd786432;
    assign w_smag  = w_tcf[48] ? 49'(-w_tcf) : 49'(w_tcf);
    assign w_s_big = w_smag >= 49'd524288;
    assign w_a21   = (i_mode == MODE_GAUSS) ? w_ga[20:0] : 21'd0 - {w_smag[19:0], 1'b0};
    assign w_big   = {w_a21[20], w_a21, 42'b0};

    always_comb begin
        unique case (i_mode)
            MODE_LINEAR: w_early = 1'b1;
            MODE_POLY:   w_early = (i_degree == 4'd0);
            MODE_GAUSS:  w_early = w_g_hi | w_g_lo;
            default:     w_early = w_s_big;
        endcase
    end

    assign o_stat.early  = w_early;
    assign o_stat.rem_ge = r_rem >= LN2_Q58;

    assign w_pv = r_prod[63:16];
    assign w_pa = i_cmd.pp_sel[1] ? r_term[63:32] : r_term[31:0];
    assign w_pb = i_cmd.pp_sel[0] ? r_rq[63:32] : r_rq[31:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        unique case (i_cmd.pp_sel)
            2'd0:    w_pps = {64'b0, w_pp};
            2'd3:    w_pps = {w_pp, 64'b0};
            default: w_pps = {32'b0, w_pp, 32'b0};
        endcase
    end

    always_comb begin
        logic [5:0] v_rem;
        v_rem = {1'b0, r_dr};
        w_qb  = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            v_rem = {v_rem[4:0], r_dq[63-k]};
            if (v_rem >= {1'b0, i_cmd.divisor}) begin
                v_rem = v_rem - {1'b0, i_cmd.divisor};
                w_qb[DIV_STEPS-1-k] = 1'b1;
            end
        end
        w_rem6 = v_rem;
    end

    assign w_nx   = 8'(r_n);
    assign w_gsh  = 8'sd46 - w_nx;
    assign w_gsum = {1'b0, r_esum} + (65'd1 << (w_gsh[5:0] - 6'd1));
    assign w_gv   = w_gsum >> w_gsh[5:0];

    assign w_ssh = 6'(8'sd22 - w_nx);
    assign w_e40 = 41'(r_esum >> w_ssh);
    assign w_nd  = 41'h100_0000_0000 - w_e40;
    assign w_den = 42'h100_0000_0000 + 42'(w_e40);
    assign w_sub = {1'b0, r_snum} - r_sden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.op == DP_ACCUM && r_cnt < CNT_W'(MAX_FEATURES)) begin
            r_sum <= w_acc_sat;
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.op == DP_CLEAR) begin
            r_sum <= '0;
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_MULH: r_ph <= $signed(i_scale) * $signed(w_d[39:20]);
            DP_MULL: r_pl <= 45'($signed(i_scale) * $signed({1'b0, w_d[19:0]}));
            DP_SUMT: r_t <= w_st[63:16];
            DP_DISPATCH: begin
                r_rem <= w_big + REM_BIAS;
                r_n   <= N_START;
                r_neg <= w_tcf[48];
                r_tc  <= w_tcc;
                unique case (i_mode)
                    MODE_LINEAR: begin
                        r_res <= w_d_ovf ? 32'sh7FFFFFFF
                                         : (w_d_unf ? 32'sh80000000 : w_d[31:0]);
                        r_sat <= w_d_ovf | w_d_unf;
                    end
                    MODE_POLY: begin
                        r_res <= 32'sd65536;
                        r_sat <= (i_degree != 4'd0) && (w_tc_ovf | w_tc_unf);
                    end
                    MODE_GAUSS: begin
                        r_res <= w_g_hi ? 32'sh7FFFFFFF : 32'sd0;
                        r_sat <= w_g_hi;
                    end
                    default: begin
                        r_res <= w_tcf[48] ? -32'sd65536 : 32'sd65536;
                        r_sat <= 1'b0;
                    end
                endcase
            end
            DP_PMUL: r_prod <= r_res * r_tc;
            DP_PCLAMP: begin
                if (w_pv > 48'sd2147483647) begin
                    r_res <= 32'sh7FFFFFFF;
                    r_sat <= 1'b1;
                end else if (w_pv < -48'sd2147483648) begin
                    r_res <= 32'sh80000000;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= w_pv[31:0];
                end
            end
            DP_RED: begin
                if (r_rem >= LN2_Q58) begin
                    r_rem <= r_rem - LN2_Q58;
                    r_n   <= r_n + 6'sd1;
                end
            end
            DP_TINIT: begin
                r_rq   <= {r_rem[59:0], 4'b0};
                r_term <= ONE_Q62;
                r_esum <= ONE_Q62;
            end
            DP_PP: r_acc <= ((i_cmd.pp_sel == 2'd0) ? 128'd0 : r_acc) + w_pps;
            DP_DLOAD: begin
                r_dq <= r_acc[125:62];
                r_dr <= '0;
            end
            DP_DIV: begin
                r_dq <= {r_dq[63-DIV_STEPS:0], w_qb};
                r_dr <= w_rem6[4:0];
            end
            DP_TACC: begin
                r_term <= r_dq;
                r_esum <= r_esum + r_dq;
            end
            DP_GFIN: begin
                if (w_gsh >= 8'sd64) begin
                    r_res <= 32'sd0;
                end else if (w_gv > 65'h7FFFFFFF) begin
                    r_res <= 32'sh7FFFFFFF;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= w_gv[31:0];
                end
            end
            DP_SLOAD: begin
                r_snum <= {1'b0, w_nd, 16'b0} + 58'(w_den >> 1);
                r_sden <= {w_den, 17'b0};
                r_q    <= '0;
            end
            DP_SDIV: begin
                if (!w_sub[58]) begin
                    r_snum <= w_sub[57:0];
                end
                r_q    <= {r_q[16:0], ~w_sub[58]};
                r_sden <= r_sden >> 1;
            end
            DP_SFIN: begin
                r_res <= r_neg ? -32'(r_q) : 32'(r_q);
                r_sat <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_result.kernel_value = r_res;
    assign o_result.saturated    = r_sat;

endmodule

// ===== rtl/kfe_ctrl.sv =====
module kfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic [1:0]        i_mode,
    input  logic [3:0]        i_degree,
    input  kfe_pkg::t_dp_stat i_stat,
    input  logic              i_out_free,
    output logic              o_in_ready,
    output logic              o_out_load,
    output kfe_pkg::t_dp_cmd  o_cmd
);
    import kfe_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'd1 << 0,
        S_MULH  = 17'd1 << 1,
        S_MULL  = 17'd1 << 2,
        S_SUMT  = 17'd1 << 3,
        S_DISP  = 17'd1 << 4,
        S_PMUL  = 17'd1 << 5,
        S_PCLP  = 17'd1 << 6,
        S_RED   = 17'd1 << 7,
        S_TINIT = 17'd1 << 8,
        S_PP    = 17'd1 << 9,
        S_DLOAD = 17'd1 << 10,
        S_DIV   = 17'd1 << 11,
        S_TACC  = 17'd1 << 12,
        S_POST  = 17'd1 << 13,
        S_SDIV  = 17'd1 << 14,
        S_SFIN  = 17'd1 << 15,
        S_DONE  = 17'd1 << 16
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_term_i, n_term_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_term_i <= 5'd1;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_term_i <= n_term_i;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_term_i      = r_term_i;
        o_in_ready    = 1'b0;
        o_out_load    = 1'b0;
        o_cmd.op      = DP_NOP;
        o_cmd.pp_sel  = r_cnt[1:0];
        o_cmd.divisor = r_term_i;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_ACCUM;
                    if (i_in_last) begin
                        n_state = S_MULH;
                    end
                end
            end
            S_MULH: begin
                o_cmd.op = DP_MULH;
                n_state  = S_MULL;
            end
            S_MULL: begin
                o_cmd.op = DP_MULL;
                n_state  = S_SUMT;
            end
            S_SUMT: begin
                o_cmd.op = DP_SUMT;
                n_state  = S_DISP;
            end
            S_DISP: begin
                o_cmd.op = DP_DISPATCH;
                if (i_stat.early) begin
                    n_state = S_DONE;
                end else if (i_mode == MODE_POLY) begin
                    n_cnt   = 5'(i_degree);
                    n_state = S_PMUL;
                end else begin
                    n_state = S_RED;
                end
            end
            S_PMUL: begin
                o_cmd.op = DP_PMUL;
                n_state  = S_PCLP;
            end
            S_PCLP: begin
                o_cmd.op = DP_PCLAMP;
                n_cnt    = r_cnt - 5'd1;
                n_state  = (r_cnt == 5'd1) ? S_DONE : S_PMUL;
            end
            S_RED: begin
                o_cmd.op = DP_RED;
                if (!i_stat.rem_ge) begin
                    n_state = S_TINIT;
                end
            end
            S_TINIT: begin
                o_cmd.op = DP_TINIT;
                n_term_i = 5'd1;
                n_cnt    = '0;
                n_state  = S_PP;
            end
            S_PP: begin
                o_cmd.op = DP_PP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd3) begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.op = DP_DLOAD;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_TACC;
                end
            end
            S_TACC: begin
                o_cmd.op = DP_TACC;
                n_cnt    = '0;
                if (r_term_i == 5'(TAYLOR_TERMS)) begin
                    n_state = S_POST;
                end else begin
                    n_term_i = r_term_i + 5'd1;
                    n_state  = S_PP;
                end
            end
            S_POST: begin
                n_cnt = '0;
                if (i_mode == MODE_GAUSS) begin
                    o_cmd.op = DP_GFIN;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = DP_SLOAD;
                    n_state  = S_SDIV;
                end
            end
            S_SDIV: begin
                o_cmd.op = DP_SDIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(SDIV_STEPS - 1)) begin
                    n_state = S_SFIN;
                end
            end
            S_SFIN: begin
                o_cmd.op = DP_SFIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_cmd.op   = DP_CLEAR;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import kfe_pkg::*;

    localparam int HOLD_CYCLES  = 2000;
    localparam int SETTLE       = 400;
    localparam int WDOG_LIMIT   = 20000;
    localparam longint LN2      = longint'(LN2_Q58);
    localparam longint SAT_HI   = 64'sh00007FFFFFFFFFFF;
    localparam longint SAT_LO   = -SAT_HI - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_kfe_in     in_data;
    logic        out_valid;
    logic        out_ready;
    t_kfe_out    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    t_kfe_in  feature_q[$];
    t_kfe_out kernel_q[$];
    int       gap_left;
    int       stall_left;
    int       holds_asked;
    int       holds_done;
    int       pushed;
    int       taken;
    int       errors;
    int       quiet_cycles;
    bit       no_gaps;

    logic [1:0]  cur_mode;
    logic [23:0] cur_scale;
    logic [23:0] cur_offset;
    logic [3:0]  cur_degree;
    longint      dot_sum;
    int          feat_count;

    kernel_function_evaluator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] mul_q62(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    function automatic logic [63:0] exp_series(longint a, output longint n);
        longint      big;
        longint      r;
        logic [63:0] rq;
        logic [63:0] term;
        logic [63:0] acc;
        big = a <<< 42;
        n = big / LN2;
        r = big - n * LN2;
        if (r < 0) begin
            r = r + LN2;
            n = n - 1;
        end
        rq = 64'(r) << 4;
        term = ONE_Q62;
        acc = ONE_Q62;
        for (int i = 1; i <= TAYLOR_TERMS; i++) begin
            term = mul_q62(term, rq) / 64'(i);
            acc = acc + term;
        end
        return acc;
    endfunction

    function automatic longint gauss_value(longint a, inout bit flag);
        longint      n;
        logic [63:0] acc;
        logic [63:0] v;
        longint      sh;
        if (a > 64'sd11 * 65536) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (a < -64'sd12 * 65536) return 0;
        acc = exp_series(a, n);
        sh = 46 - n;
        if (sh >= 64) return 0;
        v = (acc + (64'd1 << (sh - 1))) >> sh;
        return clip32(longint'(v), flag);
    endfunction

    function automatic longint tanh_value(longint t);
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] e40;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        longint      n;
        mag = (t < 0) ? 64'(-t) : 64'(t);
        if (mag >= 64'd8 * 65536) return (t < 0) ? -64'sd65536 : 64'sd65536;
        acc = exp_series(-2 * longint'(mag), n);
        e40 = acc >> (22 - n);
        num = ((64'd1 << 40) - e40) << 16;
        den = (64'd1 << 40) + e40;
        q = (num + den / 2) / den;
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void accumulate_feature(t_kfe_in it);
        longint x1;
        longint x2;
        longint d;
        longint s;
        longint c;
        longint t;
        longint tc;
        longint val;
        bit     sat;
        bit     tsat;
        t_kfe_out res;
        x1 = longint'(it.x1_feature);
        x2 = longint'(it.x2_feature);
        if (feat_count < MAX_FEATURES) begin
            if (cur_mode == MODE_GAUSS) d = (x1 - x2) * (x1 - x2);
            else d = x1 * x2;
            d = d + dot_sum;
            if (d > SAT_HI) d = SAT_HI;
            if (d < SAT_LO) d = SAT_LO;
            dot_sum = d;
            feat_count++;
        end
        if (!it.last_feature) return;
        sat = 1'b0;
        tsat = 1'b0;
        d = dot_sum >>> 8;
        s = longint'(signed'(cur_scale));
        c = longint'(signed'(cur_offset));
        t = (s * d) >>> 16;
        case (cur_mode)
            MODE_LINEAR: val = clip32(d, sat);
            MODE_POLY: begin
                tc = clip32(t + c, tsat);
                val = 65536;
                if (cur_degree != 0 && tsat) sat = 1'b1;
                for (int k = 0; k < cur_degree; k++) val = clip32((val * tc) >>> 16, sat);
            end
            MODE_GAUSS: val = gauss_value(-t, sat);
            default: val = tanh_value(t + c);
        endcase
        dot_sum = 0;
        feat_count = 0;
        res.kernel_value = val[31:0];
        res.saturated = sat;
        kernel_q.push_back(res);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_kfe_in it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left <= 0;
        end else if (in_valid && !in_ready) begin
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (feature_q.size() > 0) begin
            it = feature_q.pop_front();
            in_data <= it;
            in_valid <= 1'b1;
            gap_left <= no_gaps ? 0 : $urandom_range(0, 8);
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && out_ready) begin
            w = no_gaps ? 0 : $urandom_range(0, 8);
            stall_left <= w;
            out_ready <= (w == 0);
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            stall_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_kfe_out want;
        bit       moved;
        if (!i_rst_n) begin
            cur_mode <= RST_MODE;
            cur_scale <= RST_SCALE;
            cur_offset <= RST_OFFSET;
            cur_degree <= RST_DEGREE;
            dot_sum = 0;
            feat_count = 0;
            quiet_cycles <= 0;
        end else begin
            moved = (in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (in_valid && in_ready) begin
                taken <= taken + 1;
                accumulate_feature(in_data);
            end
            if (out_valid && out_ready) begin
                if (kernel_q.size() == 0) begin
                    report_mismatch("result with no expectation");
                end else begin
                    want = kernel_q.pop_front();
                    if (out_data.kernel_value !== want.kernel_value)
                        report_mismatch($sformatf("kernel_value %h expected %h",
                            out_data.kernel_value, want.kernel_value));
                    if (out_data.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated %b expected %b",
                            out_data.saturated, want.saturated));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE:   cur_mode <= cfg_data[1:0];
                    CFG_SCALE:  cur_scale <= cfg_data;
                    CFG_OFFSET: cur_offset <= cfg_data;
                    default:    cur_degree <= cfg_data[3:0];
                endcase
            end
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_feature(logic [15:0] x1, logic [15:0] x2, logic last);
        t_kfe_in it;
        it.x1_feature = x1;
        it.x2_feature = x2;
        it.last_feature = last;
        feature_q.push_back(it);
        pushed++;
    endtask

    task automatic wait_drained();
        while (pushed != taken || kernel_q.size() != 0 || feature_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_kernel(logic [1:0] m, logic [23:0] s, logic [23:0] c, logic [3:0] d);
        wait_drained();
        write_reg(CFG_MODE, {22'd0, m});
        write_reg(CFG_SCALE, s);
        write_reg(CFG_OFFSET, c);
        write_reg(CFG_DEGREE, {20'd0, d});
    endtask

    function automatic logic [15:0] rand_feature(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [23:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 262144) - 131072);
            2: return 24'($urandom_range(0, 8192) - 4096);
            default: return 24'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    initial begin
        int span;
        int len;
        int budget;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        holds_asked = 0;
        holds_done = 0;
        pushed = 0;
        taken = 0;
        errors = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_feature(16'h7FFF, 16'h8000, 1'b1);
        add_feature(16'h0100, 16'h0000, 1'b1);
        set_kernel(MODE_LINEAR, 24'd65536, 24'd0, 4'd1);
        add_feature(16'h7FFF, 16'h7FFF, 1'b0);
        add_feature(16'h8000, 16'h8000, 1'b0);
        add_feature(16'h8000, 16'h7FFF, 1'b1);
        add_feature(16'h0000, 16'h0000, 1'b1);
        set_kernel(MODE_POLY, 24'h7FFFFF, 24'h800000, 4'd0);
        add_feature(16'h0000, 16'h0000, 1'b1);
        set_kernel(MODE_POLY, 24'd0, 24'd0, 4'd0);
        add_feature(16'h1234, 16'h4321, 1'b1);
        set_kernel(MODE_POLY, 24'd65536, 24'd0, 4'd15);
        add_feature(16'h4000, 16'h4000, 1'b1);
        add_feature(16'h1000, 16'hF000, 1'b1);
        set_kernel(MODE_GAUSS, 24'h800000, 24'd0, 4'd1);
        add_feature(16'h1000, 16'h0000, 1'b1);
        set_kernel(MODE_GAUSS, 24'h7FFFFF, 24'd0, 4'd1);
        add_feature(16'h1000, 16'h0000, 1'b1);
        set_kernel(MODE_SIGMOID, 24'h7FFFFF, 24'h7FFFFF, 4'd1);
        add_feature(16'h7FFF, 16'h7FFF, 1'b1);
        set_kernel(MODE_SIGMOID, 24'd65536, 24'h800000, 4'd1);
        add_feature(16'h0800, 16'h0800, 1'b1);
        set_kernel(MODE_SIGMOID, 24'd65536, 24'd0, 4'd1);
        add_feature(16'h0400, 16'h0C00, 1'b1);

        set_kernel(MODE_LINEAR, 24'd65536, 24'd0, 4'd1);
        add_feature(16'h1000, 16'h1000, 1'b0);
        wait_drained();
        write_reg(CFG_MODE, {22'd0, MODE_GAUSS});
        add_feature(16'h2000, 16'h0000, 1'b1);

        set_kernel(MODE_LINEAR, 24'd65536, 24'd0, 4'd1);
        no_gaps = 1'b1;
        for (int i = 0; i < MAX_FEATURES + 6; i++)
            add_feature(16'h1000, 16'h1000, i == MAX_FEATURES + 5);
        wait_drained();
        no_gaps = 1'b0;

        for (int ph = 0; ph < 12; ph++) begin
            set_kernel(2'($urandom_range(0, 3)), rand_coef(), rand_coef(),
                4'($urandom_range(0, 15)));
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 5) holds_asked++;
            budget = 88;
            while (budget > 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8);
                span = ($urandom_range(0, 2) == 0) ? 0 : 4096;
                for (int k = 0; k < len; k++)
                    add_feature(rand_feature(span), rand_feature(span), k == len - 1);
                budget -= len;
            end
        end
        wait_drained();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
